FILE: src/drd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// drd_pkg: shared types and constants of the detection row decoder
// Field widths, register indexes, reset values and the row-end record that
// the row tracker hands to the pixel scaling pipeline.
// ============================================================================
package drd_pkg;

    localparam int VALUE_W    = 18;   // signed Q2.16 tensor value
    localparam int PIX_W      = 19;   // signed Q15.4 pixel value
    localparam int CLASS_W    = 8;
    localparam int COUNT_W    = 9;    // class_count register
    localparam int THRESH_W   = 17;   // score_threshold register
    localparam int DIM_W      = 13;   // image_width / image_height registers
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;

    localparam int BOX_VALUES = 4;    // cx, cy, w, h lead every row

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLASS_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    // register reset values
    localparam logic [COUNT_W-1:0]  CLASS_COUNT_RST = 9'd80;
    localparam logic [THRESH_W-1:0] THRESHOLD_RST   = 17'd32768;
    localparam logic [DIM_W-1:0]    IMAGE_DIM_RST   = 13'd640;

    // everything needed to build one box once a row has passed the threshold
    typedef struct packed {
        logic signed [VALUE_W-1:0] center_x;
        logic signed [VALUE_W-1:0] center_y;
        logic signed [VALUE_W-1:0] size_w;
        logic signed [VALUE_W-1:0] size_h;
        logic        [CLASS_W-1:0] best_class;
        logic signed [VALUE_W-1:0] best_score;
    } row_done_t;

endpackage

FILE: src/drd_in_if.sv
`timescale 1ns / 1ps
// ============================================================================
// drd_in_if: tensor value channel
// Valid/ready channel that carries one tensor value per item.
// ============================================================================
interface drd_in_if;
    import drd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] tensor_value;

    modport source (output valid, output tensor_value, input ready);
    modport sink   (input valid, input tensor_value, output ready);
endinterface

FILE: src/drd_out_if.sv
`timescale 1ns / 1ps
// ============================================================================
// drd_out_if: detection box channel
// Valid/ready channel that carries one decoded box per item.
// ============================================================================
interface drd_out_if;
    import drd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [PIX_W-1:0]   box_left;
    logic signed [PIX_W-1:0]   box_top;
    logic signed [PIX_W-1:0]   box_width;
    logic signed [PIX_W-1:0]   box_height;
    logic        [CLASS_W-1:0] class_index;
    logic signed [VALUE_W-1:0] confidence;

    modport source (output valid, output box_left, output box_top, output box_width,
                    output box_height, output class_index, output confidence,
                    input ready);
    modport sink   (input valid, input box_left, input box_top, input box_width,
                    input box_height, input class_index, input confidence,
                    output ready);
endinterface

FILE: src/detection_row_decode.sv
`timescale 1ns / 1ps
// ============================================================================
// detection_row_decode: detection tensor row to pixel box decoder
// Tracks rows of cx, cy, w, h and class scores, picks the best class and
// emits one scaled box per row whose best score reaches the threshold.
// ============================================================================
// Usage:
//   in_ch  carries one signed Q2.16 tensor value per item. Rows run back to
//          back: cx, cy, w, h, then class_count scores. No framing signal;
//          the internal position counter finds the row boundaries.
//   out_ch carries one box per passing row: left/top/width/height in signed
//          Q15.4 pixels (floored, saturated), class index and the raw score.
//   cfg    plain write port (cfg_we, cfg_index, cfg_data); write only while
//          the block is idle.
// Throughput: one value per cycle while in_ch holds ready (see Stall). Each
//   class score does a single compare and update of the argmax registers.
// Path: a passing row's box goes from the row-end register, which loads at the
//   edge that accepts the row's last value, to the product register, then
//   to the output register that drives out_ch.
// Stall: while out_ch is not ready, boxes close up in the three box stages;
//   in_ch drops ready whenever the row-end register is full and cannot
//   advance, whether or not the next value ends a row.
// Reset: registers return to their defaults (80 classes, threshold 0.5,
//   640 x 640 image), the row counter restarts at cx, pending boxes drop.
// ============================================================================
module detection_row_decode #(
    parameter int MAX_CLASSES = 256
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [drd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [drd_pkg::CFG_DATA_W-1:0]        cfg_data,
    drd_in_if.sink                                in_ch,
    drd_out_if.source                             out_ch
);
    import drd_pkg::*;

    localparam int DX_W   = VALUE_W + 2;        // 2*cx - w
    localparam int PROD_W = DX_W + DIM_W + 1;   // signed product width

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]  class_count_reg;
    logic [THRESH_W-1:0] threshold_reg;
    logic [DIM_W-1:0]    image_width_reg;
    logic [DIM_W-1:0]    image_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_count_reg  <= CLASS_COUNT_RST;
            threshold_reg    <= THRESHOLD_RST;
            image_width_reg  <= IMAGE_DIM_RST;
            image_height_reg <= IMAGE_DIM_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CLASS_COUNT:  class_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_THRESHOLD:    threshold_reg    <= cfg_data[THRESH_W-1:0];
                CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: each stage advances when the one after it has room
    // ------------------------------------------------------------------
    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic o_valid_reg, o_valid_next;
    logic out_free, b_free, a_free;
    logic accept, emit;

    assign out_free = !o_valid_reg || out_ch.ready;
    assign b_free   = !b_valid_reg || out_free;
    assign a_free   = !a_valid_reg || b_free;

    // hold input while stage A is full and cannot advance
    assign in_ch.ready = a_free;
    assign accept      = in_ch.valid && in_ch.ready;

    row_done_t row_done;

    drd_row_track #(
        .MAX_CLASSES (MAX_CLASSES)
    ) u_row_track (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .value           (in_ch.tensor_value),
        .class_count     (class_count_reg),
        .score_threshold (threshold_reg),
        .emit            (emit),
        .done            (row_done)
    );

    // ------------------------------------------------------------------
    // Stage A: capture the passing row
    // ------------------------------------------------------------------
    row_done_t a_data_reg;

    always_comb
    begin
        if (emit)
        begin
            a_valid_next = 1'b1;
        end
        else if (b_free)
        begin
            a_valid_next = 1'b0;
        end
        else
        begin
            a_valid_next = a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            a_data_reg <= row_done;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: scale by image size (one multiplier per coordinate)
    // ------------------------------------------------------------------
    logic signed [DX_W-1:0]   dx, dy;
    logic signed [PROD_W-1:0] lx_next, ty_next, bw_next, bh_next;
    logic signed [PROD_W-1:0] lx_reg, ty_reg, bw_reg, bh_reg;
    logic        [CLASS_W-1:0] b_class_reg;
    logic signed [VALUE_W-1:0] b_score_reg;
    logic b_load;

    assign b_load = a_valid_reg && b_free;

    always_comb
    begin
        // w/2 is exact at twice the scale, so left = (2*cx - w) * width
        dx = {a_data_reg.center_x[VALUE_W-1], a_data_reg.center_x, 1'b0}
             - DX_W'(a_data_reg.size_w);
        dy = {a_data_reg.center_y[VALUE_W-1], a_data_reg.center_y, 1'b0}
             - DX_W'(a_data_reg.size_h);
        lx_next = PROD_W'(dx) * PROD_W'($signed({1'b0, image_width_reg}));
        ty_next = PROD_W'(dy) * PROD_W'($signed({1'b0, image_height_reg}));
        bw_next = PROD_W'(a_data_reg.size_w) * PROD_W'($signed({1'b0, image_width_reg}));
        bh_next = PROD_W'(a_data_reg.size_h) * PROD_W'($signed({1'b0, image_height_reg}));

        if (b_load)
        begin
            b_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            b_valid_next = 1'b0;
        end
        else
        begin
            b_valid_next = b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            lx_reg      <= lx_next;
            ty_reg      <= ty_next;
            bw_reg      <= bw_next;
            bh_reg      <= bh_next;
            b_class_reg <= a_data_reg.best_class;
            b_score_reg <= a_data_reg.best_score;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: floor to Q15.4 and saturate
    // ------------------------------------------------------------------
    function automatic logic signed [PIX_W-1:0] sat_pix(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] hi, lo;
        hi = PROD_W'((1 << (PIX_W - 1)) - 1);
        lo = -PROD_W'(1 << (PIX_W - 1));
        if (v > hi)
        begin
            sat_pix = hi[PIX_W-1:0];
        end
        else if (v < lo)
        begin
            sat_pix = lo[PIX_W-1:0];
        end
        else
        begin
            sat_pix = v[PIX_W-1:0];
        end
    endfunction

    logic signed [PIX_W-1:0]   left_reg, top_reg, width_reg, height_reg;
    logic        [CLASS_W-1:0] class_reg;
    logic signed [VALUE_W-1:0] conf_reg;
    logic o_load;

    assign o_load = b_valid_reg && out_free;

    always_comb
    begin
        if (o_load)
        begin
            o_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            o_valid_next = 1'b0;
        end
        else
        begin
            o_valid_next = o_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (o_load)
        begin
            // arithmetic shift floors toward minus infinity
            left_reg   <= sat_pix(lx_reg >>> 13);
            top_reg    <= sat_pix(ty_reg >>> 13);
            width_reg  <= sat_pix(bw_reg >>> 12);
            height_reg <= sat_pix(bh_reg >>> 12);
            class_reg  <= b_class_reg;
            conf_reg   <= b_score_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            o_valid_reg <= o_valid_next;
        end
    end

    assign out_ch.valid       = o_valid_reg;
    assign out_ch.box_left    = left_reg;
    assign out_ch.box_top     = top_reg;
    assign out_ch.box_width   = width_reg;
    assign out_ch.box_height  = height_reg;
    assign out_ch.class_index = class_reg;
    assign out_ch.confidence  = conf_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_stage_a_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !b_free) |=> a_valid_reg)
        else $error("stage A box lost while stage B was blocked");

    a_stage_b_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(b_valid_reg) |-> $past(a_valid_reg))
        else $error("stage B filled without a row in stage A");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(o_valid_reg) |-> $past(b_valid_reg))
        else $error("output filled without products in stage B");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> a_free)
        else $error("row end accepted while stage A was full");
`endif

endmodule

FILE: src/drd_row_track.sv
`timescale 1ns / 1ps
// ============================================================================
// drd_row_track: row position, box values and running class argmax
// Consumes one tensor value per cycle while accept is high and flags the
// row end whose best score reaches the threshold.
// ============================================================================
module drd_row_track #(
    parameter int MAX_CLASSES = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic signed [drd_pkg::VALUE_W-1:0]  value,
    input  logic        [drd_pkg::COUNT_W-1:0]  class_count,
    input  logic        [drd_pkg::THRESH_W-1:0] score_threshold,
    output logic                                emit,
    output drd_pkg::row_done_t                  done
);
    import drd_pkg::*;

    localparam int POS_W = $clog2(MAX_CLASSES + BOX_VALUES);
    localparam int LW    = ((POS_W > COUNT_W) ? POS_W : COUNT_W) + 1;

    logic        [POS_W-1:0]   pos_reg, pos_next;
    logic signed [VALUE_W-1:0] cx_reg, cy_reg, w_reg, h_reg;
    logic signed [VALUE_W-1:0] best_reg, best_next;
    logic        [CLASS_W-1:0] cls_reg, cls_next;

    logic [LW-1:0] count_ext, eff_count, last_pos, pos_ext, class_pos;
    logic          is_box, row_end, pass;

    always_comb
    begin
        count_ext = LW'(class_count);
        if (class_count == '0)
        begin
            eff_count = LW'(1);
        end
        else if (count_ext > LW'(MAX_CLASSES))
        begin
            eff_count = LW'(MAX_CLASSES);
        end
        else
        begin
            eff_count = count_ext;
        end
        last_pos  = eff_count + LW'(BOX_VALUES - 1);
        pos_ext   = LW'(pos_reg);
        class_pos = pos_ext - LW'(BOX_VALUES);
        is_box    = (pos_ext < LW'(BOX_VALUES));

        // first score of the row seeds the argmax; later ones win only if larger
        if (pos_ext == LW'(BOX_VALUES))
        begin
            best_next = value;
            cls_next  = '0;
        end
        else if (value > best_reg)
        begin
            best_next = value;
            cls_next  = class_pos[CLASS_W-1:0];
        end
        else
        begin
            best_next = best_reg;
            cls_next  = cls_reg;
        end

        // a count lowered mid-row ends the row at the current value
        row_end  = !is_box && (pos_ext >= last_pos);
        pos_next = row_end ? '0 : pos_reg + POS_W'(1);
        pass     = $signed({best_next[VALUE_W-1], best_next})
                   >= $signed({2'b00, score_threshold});
    end

    assign emit = accept && row_end && pass;

    always_comb
    begin
        done.center_x   = cx_reg;
        done.center_y   = cy_reg;
        done.size_w     = w_reg;
        done.size_h     = h_reg;
        done.best_class = cls_next;
        done.best_score = best_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            cx_reg   <= '0;
            cy_reg   <= '0;
            w_reg    <= '0;
            h_reg    <= '0;
            best_reg <= '0;
            cls_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg <= pos_next;
            if (is_box)
            begin
                case (pos_reg[1:0])
                    2'd0:    cx_reg <= value;
                    2'd1:    cy_reg <= value;
                    2'd2:    w_reg  <= value;
                    default: h_reg  <= value;
                endcase
            end
            else
            begin
                best_reg <= best_next;
                cls_reg  <= cls_next;
            end
        end
    end

endmodule

FILE: tb/sv/detection_row_decode_test.sv
`timescale 1ns / 1ps
// ============================================================================
// detection_row_decode_test: self-checking bench for the detection row decoder
// Streams rows of box values and class scores through the tensor channel,
// mirrors the row tracking and pixel scaling in a local model and compares
// every decoded box, field by field, against the oldest predicted one.
// ============================================================================
module detection_row_decode_test;
    import drd_pkg::*;

    localparam int MAX_CLASSES  = 256;
    localparam int RANDOM_ITEMS = 1400;
    localparam int DRAIN_CYCLES = 8;       // three box stages plus margin
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PIX_MAX      = 262143;
    localparam int PIX_MIN      = -262144;
    localparam int VALUE_MAX    = 131071;
    localparam int VALUE_MIN    = -131072;

    typedef struct packed {
        logic signed [PIX_W-1:0]   left;
        logic signed [PIX_W-1:0]   top;
        logic signed [PIX_W-1:0]   width;
        logic signed [PIX_W-1:0]   height;
        logic        [CLASS_W-1:0] cls;
        logic signed [VALUE_W-1:0] score;
    } box_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    drd_in_if  in_ch ();
    drd_out_if out_ch ();

    detection_row_decode #(
        .MAX_CLASSES (MAX_CLASSES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // ------------------------------------------------------------------------
    // Mirror of the decoder: row position, held box values, running argmax
    // and the four registers as the block sees them.
    // ------------------------------------------------------------------------
    int row_pos    = 0;
    int ctr_x      = 0;
    int ctr_y      = 0;
    int size_w     = 0;
    int size_h     = 0;
    int best_score = 0;
    int best_class = 0;

    int class_count_reg  = CLASS_COUNT_RST;
    int threshold_reg    = THRESHOLD_RST;
    int image_width_reg  = IMAGE_DIM_RST;
    int image_height_reg = IMAGE_DIM_RST;

    box_t                      expected_boxes[$];
    logic signed [VALUE_W-1:0] pending_values[$];

    int   error_count   = 0;
    int   random_items  = 0;
    int   cycle_count   = 0;
    int   send_idle_pct = 16;
    int   recv_idle_pct = 51;
    logic in_fire;

    // Zero classes count as one; anything above the build limit is clipped.
    function automatic int effective_classes(input int cnt);
        if (cnt == 0)
            return 1;
        if (cnt > MAX_CLASSES)
            return MAX_CLASSES;
        return cnt;
    endfunction

    // Floor the exact product to Q15.4 and saturate to the 19-bit range.
    function automatic logic signed [PIX_W-1:0] to_pixels(input longint raw, input int shift);
        longint r;
        r = raw >>> shift;
        if (r > PIX_MAX)
            r = PIX_MAX;
        if (r < PIX_MIN)
            r = PIX_MIN;
        return r[PIX_W-1:0];
    endfunction

    // Advance the mirror by one accepted tensor value; queue a box at a
    // passing row end.
    task automatic decode_value(input logic signed [VALUE_W-1:0] v);
        int     val;
        int     last_pos;
        longint wd;
        longint ht;
        box_t   box;
        val      = v;
        last_pos = BOX_VALUES + effective_classes(class_count_reg) - 1;
        if (row_pos < BOX_VALUES)
        begin
            case (row_pos)
                0:       ctr_x  = val;
                1:       ctr_y  = val;
                2:       size_w = val;
                default: size_h = val;
            endcase
            row_pos++;
        end
        else
        begin
            // first score seeds the argmax; later ones win only when strictly higher
            if (row_pos == BOX_VALUES)
            begin
                best_score = val;
                best_class = 0;
            end
            else if (val > best_score)
            begin
                best_score = val;
                best_class = (row_pos - BOX_VALUES) & 8'hFF;
            end
            // a position at or past the last score (class count lowered) ends the row
            if (row_pos < last_pos)
            begin
                row_pos++;
            end
            else
            begin
                row_pos = 0;
                if (best_score >= threshold_reg)
                begin
                    wd         = longint'(image_width_reg);
                    ht         = longint'(image_height_reg);
                    box.left   = to_pixels((2 * longint'(ctr_x) - longint'(size_w)) * wd, 13);
                    box.top    = to_pixels((2 * longint'(ctr_y) - longint'(size_h)) * ht, 13);
                    box.width  = to_pixels(longint'(size_w) * wd, 12);
                    box.height = to_pixels(longint'(size_h) * ht, 12);
                    box.cls    = best_class[CLASS_W-1:0];
                    box.score  = best_score[VALUE_W-1:0];
                    expected_boxes.insert(expected_boxes.size(), box);
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[detection_row_decode] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driver: change inputs at the falling edge. Hold the current item until
    // the rising edge has taken it, then advance to the next pending one or
    // drop valid. Toggle the box channel ready at random.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_ch.valid || in_fire)
            begin
                if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_ch.valid        <= 1'b1;
                    in_ch.tensor_value <= pending_values.pop_front();
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample at the rising edge. Check the box taken at this edge,
    // then apply a register write, then feed an accepted value to the mirror.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : box_monitor
        box_t want;
        if (!rst_n)
        begin
            in_fire    <= 1'b0;
            row_pos    = 0;
            ctr_x      = 0;
            ctr_y      = 0;
            size_w     = 0;
            size_h     = 0;
            best_score = 0;
            best_class = 0;
        end
        else
        begin
            in_fire <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_boxes.size() == 0)
                begin
                    error_count++;
                    $display("%0t: box with none expected, expected nothing, got left %0d class %0d",
                             $time, out_ch.box_left, out_ch.class_index);
                end
                else
                begin
                    want = expected_boxes.pop_front();
                    check_field("box_left", want.left, out_ch.box_left);
                    check_field("box_top", want.top, out_ch.box_top);
                    check_field("box_width", want.width, out_ch.box_width);
                    check_field("box_height", want.height, out_ch.box_height);
                    check_field("class_index", want.cls, out_ch.class_index);
                    check_field("confidence", want.score, out_ch.confidence);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CLASS_COUNT:  class_count_reg  = cfg_data[COUNT_W-1:0];
                    CFG_THRESHOLD:    threshold_reg    = cfg_data[THRESH_W-1:0];
                    CFG_IMAGE_WIDTH:  image_width_reg  = cfg_data[DIM_W-1:0];
                    CFG_IMAGE_HEIGHT: image_height_reg = cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
                decode_value(in_ch.tensor_value);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // One register write; return on a rising edge so pending items can be
    // queued without racing the driver.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_regs(input int cnt, input int thr, input int wd, input int ht);
        write_reg(CFG_CLASS_COUNT, cnt);
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_IMAGE_WIDTH, wd);
        write_reg(CFG_IMAGE_HEIGHT, ht);
    endtask

    // Wait until every value is taken and every box has come out, then let
    // the box stages settle so a failing row end cannot meet a register write.
    task automatic wait_idle();
        while (pending_values.size() != 0 || in_ch.valid || expected_boxes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic int pick_coord();
        case ($urandom_range(9))
            0:       return $urandom_range(0, 262143) - 131072;
            1:       return VALUE_MAX;
            2:       return VALUE_MIN;
            3:       return 0;
            default: return $urandom_range(0, 65536);     // 0.0 .. 1.0
        endcase
    endfunction

    // Scores cluster around the threshold so rows pass and fail alike;
    // repeat the previous score now and then to force ties.
    function automatic int pick_score(input int thr, input int prev);
        int s;
        case ($urandom_range(9))
            0:       s = $urandom_range(0, 262143) - 131072;
            1:       s = VALUE_MAX;
            2:       s = VALUE_MIN;
            3, 4:    s = prev;
            5:       s = thr;
            default: s = thr + $urandom_range(0, 2048) - 1024;
        endcase
        if (s > VALUE_MAX)
            s = VALUE_MAX;
        if (s < VALUE_MIN)
            s = VALUE_MIN;
        return s;
    endfunction

    function automatic int pick_count();
        case ($urandom_range(15))
            0:       return 0;
            1:       return MAX_CLASSES;
            2:       return $urandom_range(MAX_CLASSES + 1, 511);
            3, 4:    return $urandom_range(9, 40);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic int pick_threshold();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 65536;
            2:       return 131071;
            3:       return $urandom_range(0, 131071);
            default: return $urandom_range(0, 65536);
        endcase
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 1;
            2:       return 8191;
            3:       return 4096;
            4:       return 640;
            5:       return $urandom_range(0, 8191);
            default: return $urandom_range(1, 4096);
        endcase
    endfunction

    // Queue the first keep values of a row with n_scores class scores.
    task automatic queue_row(input int n_scores, input int keep, input int thr);
        int k;
        int v;
        int prev;
        prev = 0;
        for (k = 0; k < keep && k < BOX_VALUES + n_scores; k++)
        begin
            if (k < BOX_VALUES)
            begin
                v = pick_coord();
            end
            else
            begin
                v    = pick_score(thr, prev);
                prev = v;
            end
            pending_values.insert(pending_values.size(), VALUE_W'(v));
            random_items++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int cnt;
        int thr;
        int classes;
        int rows;
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_CLASS_COUNT;
        cfg_data           = '0;
        in_ch.valid        = 1'b0;
        in_ch.tensor_value = '0;
        out_ch.ready       = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Two classes, zero threshold, widest image: saturated corners with a
        // tie between zero scores, then a row whose scores are all negative.
        write_regs(2, 0, 8191, 1);
        pending_values = {VALUE_MAX, VALUE_MIN, VALUE_MIN, VALUE_MAX, 0, 0,
                          65536, 0, VALUE_MAX, -1, -1, VALUE_MIN};
        wait_idle();

        // Zero class count means one score; score equal to the threshold (1.0)
        // passes; zero image width flattens x and w.
        write_regs(0, 65536, 0, 4096);
        pending_values = {1000, -1000, 5, 7, 65536};
        wait_idle();

        // Stop eight classes mid-row, then lower the count below the current
        // position so the next value closes the row.
        write_regs(8, 0, 1, 8191);
        pending_values = {32768, -32768, 1, VALUE_MAX, -7, VALUE_MAX, VALUE_MAX};
        wait_idle();
        write_reg(CFG_CLASS_COUNT, 1);
        pending_values = {-9};

        // Random phases: mostly whole rows, sometimes a cut row before the
        // next register change.
        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            if (random_items < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 16;
                recv_idle_pct = 51;
            end
            else if (random_items < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 51;
                recv_idle_pct = 16;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            cnt = pick_count();
            thr = pick_threshold();
            write_regs(cnt, thr, pick_dim(), pick_dim());
            classes = effective_classes(cnt);
            rows    = (classes > 64) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            repeat (rows) queue_row(classes, BOX_VALUES + classes, thr);
            if ($urandom_range(3) == 0)
                queue_row(classes, $urandom_range(1, BOX_VALUES + classes - 1), thr);
        end

        wait_idle();
        if (error_count == 0)
            $display("[detection_row_decode] OK");
        else
            $display("[detection_row_decode] ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
src/drd_pkg.sv
src/drd_in_if.sv
src/drd_out_if.sv
src/drd_row_track.sv
src/detection_row_decode.sv
tb/sv/detection_row_decode_test.sv
